// ===== rtl/scbs_pkg.sv =====
// Shared constants, types and weight function for the subpixel crop shift block.
package scbs_pkg;

    // Geometry: the input tile is one column and one row larger than the output tile
    localparam int TILE_SIZE = 256;
    localparam int LINE_LEN  = TILE_SIZE + 1;
    localparam int CNT_W     = $clog2(LINE_LEN);

    // Pixel layout: red, green, blue from the lowest byte up
    localparam int CH_W    = 8;
    localparam int N_LANES = 3;
    localparam int PIX_W   = CH_W * N_LANES;

    // Fixed-point weights in units of 1/1024
    localparam int FRAC_BITS = 10;
    localparam int UNIT      = 1 << FRAC_BITS;
    localparam int WT_W      = FRAC_BITS + 1;
    localparam int SHIFT_SQ  = 2 * FRAC_BITS;
    localparam int HALF_SQ   = (UNIT * UNIT) / 2;

    // Blend widths: first pass is pixel times weight, second adds the other weight
    localparam int TOP_W = CH_W + WT_W;
    localparam int ACC_W = TOP_W + WT_W + 1;

    // Configuration port
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int SCALE_W    = 4;
    localparam logic [CFG_ADDR_W-1:0] CFG_CROP_X = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_CROP_Y = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE  = CFG_ADDR_W'(2);

    // Weight set shared by all lanes for one window
    typedef struct packed {
        logic [WT_W-1:0] xs;
        logic [WT_W-1:0] xi;
        logic [WT_W-1:0] ys;
        logic [WT_W-1:0] yi;
    } t_weights;

    // Subpixel fraction of an offset at the given scale, in 1/1024 units
    function automatic logic [WT_W-1:0] sub_weight(input logic [CFG_W-1:0] offset,
                                                   input logic [SCALE_W-1:0] scale);
        logic [CFG_W-1:0]           mask;
        logic [CFG_W-1:0]           frac;
        logic [CFG_W+FRAC_BITS-1:0] wide;
        mask = CFG_W'((CFG_W+1)'(1) << scale) - CFG_W'(1);
        frac = offset & mask;
        wide = {frac, {FRAC_BITS{1'b0}}} >> scale;
        return wide[WT_W-1:0];
    endfunction

endpackage

// ===== rtl/scbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/scbs_lane.sv =====
// One color lane: two-pass bilinear blend of a 2x2 window of 8-bit samples.
module scbs_lane
    import scbs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_load,
    input  logic [CH_W-1:0] i_upper_left,
    input  logic [CH_W-1:0] i_upper,
    input  logic [CH_W-1:0] i_left,
    input  logic [CH_W-1:0] i_cur,
    input  t_weights        i_wt,
    output logic [CH_W-1:0] o_value
);

    logic [TOP_W-1:0] r_top;
    logic [TOP_W-1:0] r_bot;
    logic [TOP_W-1:0] n_top;
    logic [TOP_W-1:0] n_bot;
    logic [ACC_W-1:0] acc;

    // Horizontal pass over the upper and lower pairs
    assign n_top = TOP_W'(i_upper_left) * TOP_W'(i_wt.xi) + TOP_W'(i_upper) * TOP_W'(i_wt.xs);
    assign n_bot = TOP_W'(i_left) * TOP_W'(i_wt.xi) + TOP_W'(i_cur) * TOP_W'(i_wt.xs);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_top <= n_top;
            r_bot <= n_bot;
        end
    end

    // Vertical pass, round and drop the fraction
    assign acc = ACC_W'(r_top) * ACC_W'(i_wt.yi) + ACC_W'(r_bot) * ACC_W'(i_wt.ys)
               + ACC_W'(HALF_SQ);
    assign o_value = acc[SHIFT_SQ +: CH_W];

endmodule

// ===== rtl/subpixel_crop_bilinear_shift_unit.sv =====
// Top level: position tracking, line store, three color lanes and the output register.
//
//  Channel   Signals                              Payload (lowest bit up)
//  s_axis    s_axis_tvalid/tready/tdata/tuser     tdata: red_in, green_in, blue_in;
//                                                 tuser: tile_start
//  m_axis    m_axis_tvalid/tready/tdata/tlast     tdata: red_out, green_out, blue_out;
//                                                 tlast: tile_last
//  cfg       i_cfg_we/i_cfg_addr/i_cfg_wdata      0 crop_offset_x, 1 crop_offset_y,
//                                                 2 scale_level
//
// Each pixel runs through the line RAM read, then the horizontal and the vertical
// multiply passes of the lanes. A new pixel is taken once the previous one is done.
// The output register holds a result while the next pixel is read in; a pixel whose
// result finds that register still full waits in the last pass until it drains.
// Reset is synchronous and clears position, neighbors and handshake state; the line
// RAM needs no clearing, a window reads it only after the first row was written.
module subpixel_crop_bilinear_shift_unit
    import scbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input pixels
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                  s_axis_tuser,  // tile_start
    // output pixels
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,  // red_out, green_out, blue_out
    output logic                  m_axis_tlast,  // tile_last
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS1,
        S_PASS2
    } t_state;

    t_state                r_state;
    logic [CFG_W-1:0]      r_crop_x;
    logic [CFG_W-1:0]      r_crop_y;
    logic [SCALE_W-1:0]    r_scale;
    logic [CNT_W-1:0]      r_col;
    logic [CNT_W-1:0]      r_row;
    logic [CNT_W-1:0]      r_pix_col;
    logic [PIX_W-1:0]      r_cur;
    logic [PIX_W-1:0]      r_left;
    logic [PIX_W-1:0]      r_upper_left;
    logic                  r_win;
    logic                  r_last;
    t_weights              r_wt;
    logic                  r_out_valid;
    logic [PIX_W-1:0]      r_out_data;
    logic                  r_out_last;

    logic                  in_acc;
    logic [CNT_W-1:0]      col_eff;
    logic [CNT_W-1:0]      row_eff;
    logic [PIX_W-1:0]      up_pix;
    logic [PIX_W-1:0]      lane_out;
    logic                  out_busy;
    logic                  out_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // Position of the incoming pixel; a start mark restarts the tile
    assign col_eff  = s_axis_tuser ? '0 : r_col;
    assign row_eff  = s_axis_tuser ? '0 : r_row;
    assign out_busy = r_out_valid && !m_axis_tready;
    assign out_load = (r_state == S_PASS2) && r_win && !out_busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crop_x <= '0;
            r_crop_y <= '0;
            r_scale  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CROP_X: r_crop_x <= i_cfg_wdata;
                CFG_CROP_Y: r_crop_y <= i_cfg_wdata;
                CFG_SCALE:  r_scale  <= i_cfg_wdata[SCALE_W-1:0];
                default:    ;
            endcase
        end
    end

    // Line store: read at acceptance, overwrite with the new pixel in the first pass
    scbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_LEN)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PASS1),
        .i_waddr (r_pix_col),
        .i_wdata (r_cur),
        .i_raddr (col_eff),
        .o_rdata (up_pix)
    );

    // Color lanes
    for (genvar k = 0; k < N_LANES; k++) begin : g_lane
        scbs_lane u_lane (
            .i_clk        (i_clk),
            .i_load       (r_state == S_PASS1),
            .i_upper_left (r_upper_left[k*CH_W +: CH_W]),
            .i_upper      (up_pix[k*CH_W +: CH_W]),
            .i_left       (r_left[k*CH_W +: CH_W]),
            .i_cur        (r_cur[k*CH_W +: CH_W]),
            .i_wt         (r_wt),
            .o_value      (lane_out[k*CH_W +: CH_W])
        );
    end

    // Sequencer, position, neighbors and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_col        <= '0;
            r_row        <= '0;
            r_left       <= '0;
            r_upper_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // load a finished result, else drain the output register
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= lane_out;
                r_out_last  <= r_last;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cur     <= s_axis_tdata;
                        r_pix_col <= col_eff;
                        r_win     <= (col_eff != '0) && (row_eff != '0);
                        r_last    <= (col_eff == CNT_W'(TILE_SIZE))
                                  && (row_eff == CNT_W'(TILE_SIZE));
                        r_wt.xs   <= sub_weight(r_crop_x, r_scale);
                        r_wt.xi   <= WT_W'(UNIT) - sub_weight(r_crop_x, r_scale);
                        r_wt.ys   <= sub_weight(r_crop_y, r_scale);
                        r_wt.yi   <= WT_W'(UNIT) - sub_weight(r_crop_y, r_scale);
                        // advance the position, wrap at the end of the tile
                        if (col_eff == CNT_W'(TILE_SIZE)) begin
                            r_col <= '0;
                            r_row <= (row_eff == CNT_W'(TILE_SIZE)) ? '0 : row_eff + 1'b1;
                        end else begin
                            r_col <= col_eff + 1'b1;
                            r_row <= row_eff;
                        end
                        r_state <= S_PASS1;
                    end
                end
                S_PASS1: begin
                    r_upper_left <= up_pix;
                    r_left       <= r_cur;
                    r_state      <= S_PASS2;
                end
                S_PASS2: begin
                    // hold while a result is blocked by a full output register
                    if (!(r_win && out_busy)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Accepted pixel runs through both passes in order
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_PASS1) ##1 (r_state == S_PASS2))
        else $error("pixel sequence broken");

    // Last window of a tile leaves the position wrapped to the origin
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS2 && r_win && r_last) |-> (r_col == '0 && r_row == '0))
        else $error("position not wrapped at tile end");

    // A blocked result is not dropped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS2 && r_win && out_busy) |=>
            (r_state == S_PASS2 && r_out_valid))
        else $error("result overwrote pending output");

    // Position stays inside the input tile
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= CNT_W'(TILE_SIZE)) && (r_row <= CNT_W'(TILE_SIZE)))
        else $error("position out of range");

endmodule

// ===== tb/subpixel_crop_checker.sv =====
// Checker for the subpixel crop shift unit: watches all channels, predicts pixels, compares.
module subpixel_crop_checker
    import scbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                  s_axis_tuser,  // tile_start
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [PIX_W-1:0]      m_axis_tdata,  // red_out, green_out, blue_out
    input  logic                  m_axis_tlast,  // tile_last
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          OUT_DIM    = 256;
    localparam int          IN_DIM     = OUT_DIM + 1;
    localparam int unsigned WEIGHT_ONE = 1024;
    localparam int unsigned ROUND_HALF = 1 << 19;
    localparam int          NORM_SHIFT = 20;
    localparam int          PRINT_CAP  = 40;

    // Red sits in the lowest byte of the stream word
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    typedef struct packed {
        t_rgb px;
        logic last;
    } t_out_px;

    t_rgb       line_px [IN_DIM];
    t_rgb       left_px;
    t_rgb       upleft_px;
    int         col;
    int         row;
    logic [15:0] crop_x;
    logic [15:0] crop_y;
    logic [3:0]  scale;
    t_out_px    predicted_pixels [$];
    int         fails;

    // Subpixel fraction of an offset, in 1/1024 units
    function automatic int unsigned frac_weight(input logic [15:0] offset,
                                                input logic [3:0] lvl);
        int unsigned rem;
        rem = int'(offset) % (1 << lvl);
        return (rem * WEIGHT_ONE) >> lvl;
    endfunction

    // Rounded bilinear blend of one channel of a 2x2 window
    function automatic logic [7:0] blend_channel(input logic [7:0] ul, input logic [7:0] u,
                                                 input logic [7:0] l, input logic [7:0] c,
                                                 input int unsigned xs,
                                                 input int unsigned ys);
        int unsigned upper_mix;
        int unsigned lower_mix;
        int unsigned total;
        upper_mix = ul * (WEIGHT_ONE - xs) + u * xs;
        lower_mix = l * (WEIGHT_ONE - xs) + c * xs;
        total = upper_mix * (WEIGHT_ONE - ys) + lower_mix * ys + ROUND_HALF;
        return 8'(total >> NORM_SHIFT);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fails++;
        // keep the log short on a badly broken design
        if (fails <= PRINT_CAP)
            $display("%0t ns checker: %s got %0d, wanted %0d", $time, what, got, want);
    endtask

    // Advance the window position and queue the pixel this input closes, if any
    task automatic take_input_pixel(input logic start, input logic [PIX_W-1:0] data);
        t_rgb        cur;
        t_rgb        up;
        t_out_px     res;
        int unsigned xs;
        int unsigned ys;
        cur = t_rgb'(data);
        if (start) begin
            col = 0;
            row = 0;
        end
        up = line_px[col];
        if (row > 0 && col > 0) begin
            xs = frac_weight(crop_x, scale);
            ys = frac_weight(crop_y, scale);
            res.px.red   = blend_channel(upleft_px.red, up.red, left_px.red, cur.red, xs, ys);
            res.px.green = blend_channel(upleft_px.green, up.green, left_px.green, cur.green,
                                         xs, ys);
            res.px.blue  = blend_channel(upleft_px.blue, up.blue, left_px.blue, cur.blue,
                                         xs, ys);
            res.last     = (row == OUT_DIM && col == OUT_DIM);
            predicted_pixels.push_back(res);
        end
        upleft_px    = up;
        left_px      = cur;
        line_px[col] = cur;
        col++;
        if (col == IN_DIM) begin
            col = 0;
            row++;
            if (row == IN_DIM)
                row = 0;
        end
    endtask

    task automatic check_output_pixel(input logic [PIX_W-1:0] data, input logic last);
        t_rgb    got;
        t_out_px want;
        got = t_rgb'(data);
        if (predicted_pixels.size() == 0) begin
            report_mismatch("output pixel with none pending, red_out", got.red, 0);
            return;
        end
        want = predicted_pixels.pop_front();
        if (got.red != want.px.red)
            report_mismatch("red_out", got.red, want.px.red);
        if (got.green != want.px.green)
            report_mismatch("green_out", got.green, want.px.green);
        if (got.blue != want.px.blue)
            report_mismatch("blue_out", got.blue, want.px.blue);
        if (last != want.last)
            report_mismatch("tile_last", last, want.last);
    endtask

    // Compare outputs before taking inputs: a queued pixel is always older
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (line_px[i])
                line_px[i] = '0;
            left_px   = '0;
            upleft_px = '0;
            col       = 0;
            row       = 0;
            crop_x    = '0;
            crop_y    = '0;
            scale     = '0;
            predicted_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_CROP_X: crop_x = i_cfg_wdata;
                    CFG_CROP_Y: crop_y = i_cfg_wdata;
                    CFG_SCALE:  scale  = i_cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                check_output_pixel(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                take_input_pixel(s_axis_tuser, s_axis_tdata);
        end
        o_pending    <= predicted_pixels.size();
        o_fail_count <= fails;
    end

    initial begin
        fails        = 0;
        o_pending    = 0;
        o_fail_count = 0;
    end

endmodule

// ===== tb/tb_subpixel_crop_bilinear_shift_unit.sv =====
// Testbench top for the subpixel crop shift unit: clock, reset, stimulus and verdict.
module tb_subpixel_crop_bilinear_shift_unit
    import scbs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ROW_PIXELS     = 257;
    localparam int RANDOM_ITEMS   = 1072;
    localparam int CHUNKS         = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata;   // red_in, green_in, blue_in
    logic                  s_axis_tuser;   // tile_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [PIX_W-1:0]      m_axis_tdata;   // red_out, green_out, blue_out
    logic                  m_axis_tlast;   // tile_last
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_wdata;

    int pending;
    int fail_count;
    int sender_idle_pct;
    int stall_pct;
    int quiet_cycles;

    subpixel_crop_bilinear_shift_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    subpixel_crop_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Stall the output side at the current rate
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Count cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        return {rand_sample(), rand_sample(), rand_sample()};
    endfunction

    // Write all three registers; call only while the block is idle
    task automatic write_cfg(input int crop_x, input int crop_y, input int lvl);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_CROP_X;
        i_cfg_wdata <= CFG_W'(crop_x);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_CROP_Y;
        i_cfg_wdata <= CFG_W'(crop_y);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_SCALE;
        i_cfg_wdata <= CFG_W'(lvl);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Send one pixel after a random gap and hold it until the transaction
    task automatic send_pixel(input logic start, input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= start;
        s_axis_tdata  <= px;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Hold off input until every queued pixel is out and the pipeline is empty
    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
            1:       begin sender_idle_pct = 73; stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  stall_pct = 73; end
            default: begin sender_idle_pct = 34; stall_pct = 34; end
        endcase
    endtask

    initial begin
        int chunk_len;
        int restart_at;
        logic [23:0] ones;
        ones            = '1;
        sender_idle_pct = 0;
        stall_pct       = 0;
        quiet_cycles    = 0;
        i_rst_n         <= 1'b0;
        s_axis_tvalid   <= 1'b0;
        s_axis_tuser    <= 1'b0;
        s_axis_tdata    <= '0;
        m_axis_tready   <= 1'b1;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= CFG_CROP_X;
        i_cfg_wdata     <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: half and three-quarter weights, with high offset bits to be masked off;
        // first row alternates black and white, second row walks left/current pairs
        write_cfg(16'hFE00, 16'h0300, 10);
        for (int c = 0; c < ROW_PIXELS; c++)
            send_pixel(c == 0, (c % 2) ? ones : '0);
        for (int c = 0; c < 24; c++)
            send_pixel(1'b0, ((c >> 1) % 2) ? ones : {8'h80, 8'h01, 8'hFE});
        // restart in mid-tile
        send_pixel(1'b1, rand_pixel());
        drain_outputs();

        // Random chunks across idling modes and register settings
        chunk_len = RANDOM_ITEMS / CHUNKS;
        for (int k = 0; k < CHUNKS; k++) begin
            drain_outputs();
            set_idling(k / 2);
            case (k)
                0:       write_cfg(0, 0, 0);
                1:       write_cfg(16'hFFFF, 16'hFFFF, 15);
                2:       write_cfg(16'hFFFF, 0, 10);
                3:       write_cfg(0, 16'hFFFF, 1);
                default: write_cfg($urandom_range(65535), $urandom_range(65535),
                                   $urandom_range(15));
            endcase
            restart_at = (k % 3 == 1) ? $urandom_range(chunk_len - 1) : -1;
            for (int i = 0; i < chunk_len; i++)
                send_pixel((i == restart_at) || ($urandom_range(299) == 0), rand_pixel());
        end

        drain_outputs();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
